### sv/rdwr_pkg.sv
// Shared constants and codes for the draw-without-replacement block.
package rdwr_pkg;

  localparam int POOL_DEPTH = 256;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int CFG_W      = 9;
  localparam int DATA_W     = 8;
  localparam int RND_W      = 16;
  localparam int MOD_STEPS  = RND_W / 2;
  localparam int STEP_W     = $clog2(MOD_STEPS);

  localparam logic [CFG_W-1:0] POOL_SIZE_RESET = CFG_W'(100);

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_REFILL = 1'b1;

  // Saturate the configured size to the store depth.
  function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] size);
    logic [CFG_W-1:0] lim;
    lim = CFG_W'(POOL_DEPTH);
    return (size > lim) ? CNT_W'(lim) : CNT_W'(size);
  endfunction

endpackage

### sv/random_draw_without_replacement.sv
// Top level: pool store, remainder unit and draw/refill sequencer.

// Draws values without replacement from a pool that holds the ramp
// 0..pool_size-1 (pool_size capped at the 256-entry depth) after reset and
// after each refill transfer (tuser = 1). A draw transfer (tuser = 0) carries
// a 16-bit random number in tdata; its remainder by the live count picks a
// pool entry, which is returned in out_tdata, and the last live entry is moved
// into its place. A draw on an empty pool returns 0 with out_tuser set. A draw
// passes through S_MOD for the remainder (two dividend bits per cycle in a
// restoring unit), then S_RD_PICK, S_RD_LAST and S_WR for the read, read and
// write-back on the one-read-port pool memory, then S_DONE, which loads the
// output register. A refill or an empty draw goes straight to S_DONE: the ramp
// is restored at once by clearing a row of per-entry valid bits, and an entry
// without its valid bit reads as its own index. S_DONE waits for as long as
// the output register stays full. One item is in work at a time; a new one is
// accepted while a finished result still waits in the output register.
// pool_size takes effect at the next refill.
module random_draw_without_replacement (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rdwr_pkg::CFG_W-1:0]   cfg_wr_data,   // pool_size
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rdwr_pkg::RND_W-1:0]   in_tdata,      // random_value
  input  logic                         in_tuser,      // kind
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rdwr_pkg::DATA_W-1:0]  out_tdata,     // drawn_value
  output logic                         out_tuser      // pool_empty
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_RD_PICK,
    S_RD_LAST,
    S_WR,
    S_DONE
  } state_t;

  state_t                              state_r;
  logic [rdwr_pkg::CFG_W-1:0]          pool_size_r;
  logic [rdwr_pkg::CNT_W-1:0]          count_r;
  logic [rdwr_pkg::RND_W-1:0]          rnd_r;
  logic [rdwr_pkg::IDX_W-1:0]          rem_r;
  logic [rdwr_pkg::STEP_W-1:0]         step_r;
  logic [rdwr_pkg::DATA_W-1:0]         pick_val_r;
  logic [rdwr_pkg::DATA_W-1:0]         res_val_r;
  logic                                res_empty_r;
  logic                                out_tvalid_r;
  logic [rdwr_pkg::DATA_W-1:0]         out_tdata_r;
  logic                                out_tuser_r;

  logic [rdwr_pkg::DATA_W-1:0]         pool_mem [rdwr_pkg::POOL_DEPTH];
  logic [rdwr_pkg::POOL_DEPTH-1:0]     valid_r;
  logic [rdwr_pkg::DATA_W-1:0]         mem_q_r;
  logic                                valid_q_r;
  logic [rdwr_pkg::IDX_W-1:0]          addr_q_r;

  logic [rdwr_pkg::IDX_W-1:0]          rd_addr;
  logic [rdwr_pkg::IDX_W-1:0]          last_idx;
  logic [rdwr_pkg::DATA_W-1:0]         rd_val;
  logic                                wr_en;
  logic                                in_xfer;
  logic                                out_free;
  logic [rdwr_pkg::IDX_W:0]            cnt_ext;
  logic [rdwr_pkg::IDX_W:0]            t1;
  logic [rdwr_pkg::IDX_W:0]            t2;
  logic [rdwr_pkg::IDX_W-1:0]          r1;
  logic [rdwr_pkg::IDX_W-1:0]          r2;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign last_idx = rdwr_pkg::IDX_W'(count_r - rdwr_pkg::CNT_W'(1));
  assign rd_addr  = (state_r == S_RD_LAST) ? last_idx : rem_r;
  assign wr_en    = (state_r == S_WR);
  // An entry never written since reset or the last refill reads as its own index.
  assign rd_val   = valid_q_r ? mem_q_r : rdwr_pkg::DATA_W'(addr_q_r);

  // Two restoring remainder steps per cycle, MSB of the dividend first.
  always_comb begin
    cnt_ext = (rdwr_pkg::IDX_W + 1)'(count_r);
    t1 = {rem_r, rnd_r[rdwr_pkg::RND_W-1]};
    r1 = (t1 >= cnt_ext) ? rdwr_pkg::IDX_W'(t1 - cnt_ext) : rdwr_pkg::IDX_W'(t1);
    t2 = {r1, rnd_r[rdwr_pkg::RND_W-2]};
    r2 = (t2 >= cnt_ext) ? rdwr_pkg::IDX_W'(t2 - cnt_ext) : rdwr_pkg::IDX_W'(t2);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pool_mem[rem_r] <= rd_val;
    end
    mem_q_r  <= pool_mem[rd_addr];
    addr_q_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      valid_q_r <= 1'b0;
    end else begin
      valid_q_r <= valid_r[rd_addr];
      if (in_xfer && in_tuser == rdwr_pkg::KIND_REFILL) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[rem_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pool_size_r  <= rdwr_pkg::POOL_SIZE_RESET;
      count_r      <= rdwr_pkg::eff_size(rdwr_pkg::POOL_SIZE_RESET);
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pool_size_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          rnd_r  <= in_tdata;
          rem_r  <= '0;
          step_r <= '0;
          if (in_xfer) begin
            if (in_tuser == rdwr_pkg::KIND_REFILL) begin
              count_r     <= rdwr_pkg::eff_size(pool_size_r);
              res_val_r   <= '0;
              res_empty_r <= 1'b0;
              state_r     <= S_DONE;
            end else if (count_r == '0) begin
              res_val_r   <= '0;
              res_empty_r <= 1'b1;
              state_r     <= S_DONE;
            end else begin
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem_r  <= r2;
          rnd_r  <= rnd_r << 2;
          step_r <= step_r + rdwr_pkg::STEP_W'(1);
          if (step_r == rdwr_pkg::STEP_W'(rdwr_pkg::MOD_STEPS - 1)) begin
            state_r <= S_RD_PICK;
          end
        end
        S_RD_PICK: begin
          state_r <= S_RD_LAST;
        end
        S_RD_LAST: begin
          pick_val_r <= rd_val;
          state_r    <= S_WR;
        end
        S_WR: begin
          // The last live entry moves into the picked slot; its old copy
          // is past the new count and is never read again.
          res_val_r   <= pick_val_r;
          res_empty_r <= 1'b0;
          count_r     <= count_r - rdwr_pkg::CNT_W'(1);
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= res_val_r;
            out_tuser_r  <= res_empty_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_wr_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (count_r != '0))
    else $error("pool write-back with no live entries");

  a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |=> (count_r == $past(count_r) - rdwr_pkg::CNT_W'(1)))
    else $error("live count did not drop after a draw");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rdwr_pkg::CNT_W'(rdwr_pkg::POOL_DEPTH))
    else $error("live count above pool depth");

  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_PICK) |-> (rdwr_pkg::CNT_W'(rem_r) < count_r))
    else $error("picked entry outside live pool");

endmodule
